// ===== rtl/core/cdft_pkg.sv =====
// Package for the cube direction to face texel block.
// Holds face codes, register indexes and fixed field widths; no dependencies.
`timescale 1ns / 1ps

package cdft_pkg;

  localparam int unsigned IN_FIELD_W  = 16;
  localparam int unsigned SIZE_W      = 13;
  localparam int unsigned COORD_W     = 20;
  localparam int unsigned RATIO_BITS  = 16;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 48;

  localparam logic [SIZE_W-1:0]  SIZE_RESET = 13'd1026;
  localparam logic [SIZE_W-1:0]  SIZE_MIN   = 13'd2;
  localparam logic [COORD_W-1:0] COORD_MAX  = 20'hFFFFF;

  localparam logic [CFG_INDEX_W-1:0] CFG_FACE_HEIGHT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FACE_WIDTH  = 1'b1;

  typedef enum logic [2:0] {
    FACE_POS_X = 3'd0,
    FACE_NEG_X = 3'd1,
    FACE_POS_Y = 3'd2,
    FACE_NEG_Y = 3'd3,
    FACE_POS_Z = 3'd4,
    FACE_NEG_Z = 3'd5
  } face_t;

endpackage

// ===== rtl/core/cube_direction_to_face_texel_top.sv =====
// Cube face selection with bordered-face texel coordinates, fully pipelined.
// Depends on cdft_pkg; one restoring divider stage per quotient bit.
//
//   channel   dir   beat fields (low bit up)
//   s_axis    in    tdata: dir_x, dir_y, dir_z
//   m_axis    out   tuser: valid_res; tdata: face, row, col, zero pad
//   cfg       in    cfg_index 0 face_height, 1 face_width; write on cfg_we
//
// Pipeline stages: input, abs, face select, 17 divider steps, ratio offset,
// size multiply, output. One beat per cycle while m_axis_tready is high.
// The whole pipeline holds while a result sits in the output skid register;
// s_axis_tready is low exactly then. rst is synchronous and clears valid bits,
// the skid valid flag and restores both sizes to 1026.
`timescale 1ns / 1ps

module cube_direction_to_face_texel_top
  import cdft_pkg::*;
#(
  parameter int unsigned COMPONENT_BITS      = 16,
  parameter int unsigned COORD_FRACTION_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // dir_x, dir_y, dir_z
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // face, row, col, zero pad
  output logic                   m_axis_tuser,   // valid_res
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]      cfg_data
);

  localparam int unsigned CB   = COMPONENT_BITS;
  localparam int unsigned QW   = RATIO_BITS + 1;
  localparam int unsigned TW   = RATIO_BITS + 2;
  localparam int unsigned PW   = SIZE_W + TW;
  localparam int unsigned SH   = RATIO_BITS + 1 - COORD_FRACTION_BITS;
  localparam int unsigned EXTW = 32;

  localparam logic [TW-1:0] T_ONE     = TW'(1) << RATIO_BITS;
  localparam logic [PW-1:0] COORD_ONE = PW'(1) << COORD_FRACTION_BITS;

  logic [SIZE_W-1:0] face_height;
  logic [SIZE_W-1:0] face_width;

  logic en;

  // skid register and pipeline output
  logic                   skid_vld;
  logic [OUT_TDATA_W-1:0] skid_data;
  logic                   skid_user;
  logic                   out_vld;
  logic [OUT_TDATA_W-1:0] out_data;
  logic                   out_user;

  always_ff @(posedge clk) begin
    if (rst) begin
      face_height <= SIZE_RESET;
      face_width  <= SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FACE_HEIGHT: face_height <= cfg_data;
        CFG_FACE_WIDTH:  face_width  <= cfg_data;
      endcase
    end
  end

  assign en            = !skid_vld;
  assign s_axis_tready = en;
  assign m_axis_tvalid = skid_vld || out_vld;
  assign m_axis_tdata  = skid_vld ? skid_data : out_data;
  assign m_axis_tuser  = skid_vld ? skid_user : out_user;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_vld <= 1'b0;
    end else if (skid_vld) begin
      if (m_axis_tready) skid_vld <= 1'b0;
    end else if (out_vld && !m_axis_tready) begin
      skid_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_vld && out_vld && !m_axis_tready) begin
      skid_data <= out_data;
      skid_user <= out_user;
    end
  end

  // stage 0: input register
  logic [EXTW-1:0]      ext_x, ext_y, ext_z;
  logic                 vld0;
  logic signed [CB-1:0] x0, y0, z0;

  always_comb begin
    ext_x = EXTW'(s_axis_tdata[IN_FIELD_W-1:0]);
    ext_y = EXTW'(s_axis_tdata[2*IN_FIELD_W-1:IN_FIELD_W]);
    ext_z = EXTW'(s_axis_tdata[3*IN_FIELD_W-1:2*IN_FIELD_W]);
  end

  always_ff @(posedge clk) begin
    if (rst) vld0 <= 1'b0;
    else if (en) vld0 <= s_axis_tvalid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0 <= $signed(ext_x[CB-1:0]);
      y0 <= $signed(ext_y[CB-1:0]);
      z0 <= $signed(ext_z[CB-1:0]);
    end
  end

  // stage 1: magnitudes and signs
  logic          vld1;
  logic [CB-1:0] ax1, ay1, az1;
  logic          sx1, sy1, sz1;

  always_ff @(posedge clk) begin
    if (rst) vld1 <= 1'b0;
    else if (en) vld1 <= vld0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx1 <= x0[CB-1];
      sy1 <= y0[CB-1];
      sz1 <= z0[CB-1];
      ax1 <= x0[CB-1] ? CB'(-x0) : CB'(x0);
      ay1 <= y0[CB-1] ? CB'(-y0) : CB'(y0);
      az1 <= z0[CB-1] ? CB'(-z0) : CB'(z0);
    end
  end

  // stage 2: face select and numerator routing
  logic          xm, ym, zm;
  logic          ok_s, rn_s, cn_s;
  face_t         face_s;
  logic [CB-1:0] mag_s, ra_s, ca_s;

  always_comb begin
    xm     = (ax1 >= ay1) && (ax1 >= az1);
    ym     = (ay1 >= ax1) && (ay1 >= az1);
    zm     = (az1 >= ax1) && (az1 >= ay1);
    ok_s   = 1'b1;
    face_s = FACE_POS_X;
    mag_s  = ax1;
    ca_s   = az1;
    cn_s   = !sz1;
    ra_s   = ay1;
    rn_s   = !sy1;
    priority if (!sx1 && ax1 != '0 && xm) begin
      face_s = FACE_POS_X;
    end else if (sx1 && xm) begin
      face_s = FACE_NEG_X;
      cn_s   = sz1;
    end else if (!sy1 && ay1 != '0 && ym) begin
      face_s = FACE_POS_Y;
      mag_s  = ay1;
      ca_s   = ax1;
      cn_s   = sx1;
      ra_s   = az1;
      rn_s   = sz1;
    end else if (sy1 && ym) begin
      face_s = FACE_NEG_Y;
      mag_s  = ay1;
      ca_s   = ax1;
      cn_s   = sx1;
      ra_s   = az1;
      rn_s   = !sz1;
    end else if (!sz1 && az1 != '0 && zm) begin
      face_s = FACE_POS_Z;
      mag_s  = az1;
      ca_s   = ax1;
      cn_s   = sx1;
    end else if (sz1 && zm) begin
      face_s = FACE_NEG_Z;
      mag_s  = az1;
      ca_s   = ax1;
      cn_s   = !sx1;
    end else begin
      ok_s   = 1'b0;
      mag_s  = CB'(1);
      ca_s   = '0;
      ra_s   = '0;
    end
  end

  logic          vld2, ok2, rn2, cn2;
  face_t         face2;
  logic [CB-1:0] mag2, ra2, ca2;

  always_ff @(posedge clk) begin
    if (rst) vld2 <= 1'b0;
    else if (en) vld2 <= vld1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok2   <= ok_s;
      face2 <= face_s;
      mag2  <= mag_s;
      ra2   <= ra_s;
      ca2   <= ca_s;
      rn2   <= rn_s;
      cn2   <= cn_s;
    end
  end

  // divider stages: one quotient bit each, row and column side by side
  logic          dv_vld  [QW];
  logic          dv_ok   [QW];
  face_t         dv_face [QW];
  logic [CB-1:0] dv_mag  [QW];
  logic [CB:0]   dv_rrem [QW];
  logic [CB:0]   dv_crem [QW];
  logic [QW-1:0] dv_rq   [QW];
  logic [QW-1:0] dv_cq   [QW];
  logic          dv_rn   [QW];
  logic          dv_cn   [QW];

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic          vld_in, ok_in, rn_in, cn_in;
    face_t         face_in;
    logic [CB-1:0] mag_in;
    logic [CB:0]   r_try, c_try;
    logic [QW-1:0] rq_in, cq_in;
    logic          r_bit, c_bit;

    if (k == 0) begin : g_first
      always_comb begin
        vld_in  = vld2;
        ok_in   = ok2;
        face_in = face2;
        mag_in  = mag2;
        rn_in   = rn2;
        cn_in   = cn2;
        rq_in   = '0;
        cq_in   = '0;
        r_try   = {1'b0, ra2};
        c_try   = {1'b0, ca2};
      end
    end else begin : g_next
      always_comb begin
        vld_in  = dv_vld[k-1];
        ok_in   = dv_ok[k-1];
        face_in = dv_face[k-1];
        mag_in  = dv_mag[k-1];
        rn_in   = dv_rn[k-1];
        cn_in   = dv_cn[k-1];
        rq_in   = dv_rq[k-1];
        cq_in   = dv_cq[k-1];
        r_try   = {dv_rrem[k-1][CB-1:0], 1'b0};
        c_try   = {dv_crem[k-1][CB-1:0], 1'b0};
      end
    end

    assign r_bit = r_try >= {1'b0, mag_in};
    assign c_bit = c_try >= {1'b0, mag_in};

    always_ff @(posedge clk) begin
      if (rst) dv_vld[k] <= 1'b0;
      else if (en) dv_vld[k] <= vld_in;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_ok[k]   <= ok_in;
        dv_face[k] <= face_in;
        dv_mag[k]  <= mag_in;
        dv_rn[k]   <= rn_in;
        dv_cn[k]   <= cn_in;
        dv_rq[k]   <= {rq_in[QW-2:0], r_bit};
        dv_cq[k]   <= {cq_in[QW-2:0], c_bit};
        dv_rrem[k] <= r_bit ? r_try - {1'b0, mag_in} : r_try;
        dv_crem[k] <= c_bit ? c_try - {1'b0, mag_in} : c_try;
      end
    end
  end

  // offset stage: t = 1.0 + ratio or 1.0 - ratio by sign, in Q16
  logic          vld_t, ok_t;
  face_t         face_t_r;
  logic [TW-1:0] rq_ext, cq_ext, rt, ct;

  always_comb begin
    rq_ext = TW'(dv_rq[QW-1]);
    cq_ext = TW'(dv_cq[QW-1]);
  end

  always_ff @(posedge clk) begin
    if (rst) vld_t <= 1'b0;
    else if (en) vld_t <= dv_vld[QW-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok_t     <= dv_ok[QW-1];
      face_t_r <= dv_face[QW-1];
      rt       <= T_ONE + (dv_rn[QW-1] ? -rq_ext : rq_ext);
      ct       <= T_ONE + (dv_cn[QW-1] ? -cq_ext : cq_ext);
    end
  end

  // multiply stage: (size - 2) * t
  logic              vld_m, ok_m;
  face_t             face_m;
  logic [SIZE_W-1:0] h_span, w_span;
  logic [PW-1:0]     rprod, cprod;

  always_comb begin
    h_span = (face_height < SIZE_MIN) ? '0 : face_height - SIZE_MIN;
    w_span = (face_width  < SIZE_MIN) ? '0 : face_width  - SIZE_MIN;
  end

  always_ff @(posedge clk) begin
    if (rst) vld_m <= 1'b0;
    else if (en) vld_m <= vld_t;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok_m   <= ok_t;
      face_m <= face_t_r;
      rprod  <= PW'(h_span) * PW'(rt);
      cprod  <= PW'(w_span) * PW'(ct);
    end
  end

  // output stage: scale, add border, saturate; all zero for a zero vector
  logic [PW-1:0]      rsum, csum;
  logic [COORD_W-1:0] row_s, col_s;
  logic [2:0]         face_o;

  always_comb begin
    rsum   = COORD_ONE + (rprod >> SH);
    csum   = COORD_ONE + (cprod >> SH);
    row_s  = (rsum > PW'(COORD_MAX)) ? COORD_MAX : rsum[COORD_W-1:0];
    col_s  = (csum > PW'(COORD_MAX)) ? COORD_MAX : csum[COORD_W-1:0];
    face_o = face_m;
    if (!ok_m) begin
      row_s  = '0;
      col_s  = '0;
      face_o = FACE_POS_X;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else if (en) out_vld <= vld_m;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_user <= ok_m;
      out_data <= {5'b0, col_s, row_s, face_o};
    end
  end

endmodule

// ===== rtl/core/cdft_checker.sv =====
// Port-level checks for the cube direction to face texel block.
// Depends on cdft_pkg; bound to cube_direction_to_face_texel_top below.
`timescale 1ns / 1ps

module cdft_checker
  import cdft_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,   // face, row, col, zero pad
  input logic                   m_axis_tuser    // valid_res
);

  a_zero_vec_clear: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("zero-vector beat carries nonzero data");

  a_face_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[2:0] <= FACE_NEG_Z)
    else $error("face code out of range");

  a_ready_low_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("input ready dropped without an output stall");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled output beat changed");

endmodule

bind cube_direction_to_face_texel_top cdft_checker u_cdft_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
